FILE: sv/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg : shared types and constants for the nearest centroid classifier
// Field layout of the stream words, mode codes and distance limits.
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

   // request field widths
   localparam int MODE_W   = 2;
   localparam int CLASS_W  = 3;
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 16;

   // request tdata layout, lowest field first
   localparam int REQ_CLASS_LSB  = 0;
   localparam int REQ_CHAN_LSB   = REQ_CLASS_LSB + CLASS_W;
   localparam int REQ_SAMPLE_LSB = REQ_CHAN_LSB + CHAN_W;
   localparam int REQ_DATA_W     = 24;

   // response fields
   localparam int DIST_W     = 35;
   localparam int RSP_DATA_W = 40;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // active_classes register
   localparam int CSR_W = 3;
   localparam logic [CSR_W-1:0] ACTIVE_RESET = 3'd5;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_TRAIN    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

   // load strobes from the sequencer to the distance datapath
   typedef struct packed {
      logic cen_load;
      logic sq_load;
   } ncc_dp_ctl_type;

endpackage

`default_nettype wire

FILE: sv/ncc_capture_mem.sv
// ----------------------------------------------------------------------------
// ncc_capture_mem : capture sample store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_capture_mem #(
   parameter int DEPTH = 120,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/ncc_dist.sv
// ----------------------------------------------------------------------------
// ncc_dist : centroid and squared difference datapath
// Divides the slot sum by the capture count, then squares sample - centroid.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_dist #(
   parameter int SW   = 16,
   parameter int KW   = 2,
   parameter int SUMW = 18
) (
   input  wire logic                          clock,
   input  wire ncc_pkg::ncc_dp_ctl_type       ctl,
   input  wire logic [SUMW-1:0]               sum,
   input  wire logic [KW-1:0]                 count,
   input  wire logic [SW-1:0]                 sample,
   output logic      [2*SW-1:0]               sq
);

   import ncc_pkg::*;

   // divide by three: ceiling reciprocal, exact for sum < 2^SUMW
   localparam int M = SUMW + 1;
   localparam logic [M-1:0] R3 = M'((2**M + 2) / 3);

   logic [SW-1:0]     cen_ff;
   logic [2*SW-1:0]   sq_ff;
   logic [SUMW+M-1:0] prod3;
   logic [SW-1:0]     cen_in;
   logic [SW-1:0]     diff;
   int                cnt;

   assign prod3 = (SUMW+M)'(sum) * (SUMW+M)'(R3);
   assign cnt   = int'(count);

   always_comb begin
      case (cnt)
         1:       cen_in = sum[SW-1:0];
         2:       cen_in = sum[SW:1];
         3:       cen_in = prod3[M+SW-1:M];
         default: cen_in = sum[SW+1:2];
      endcase
   end

   assign diff = (sample >= cen_ff) ? (sample - cen_ff) : (cen_ff - sample);

   always_ff @(posedge clock) begin
      if (ctl.cen_load) begin
         cen_ff <= cen_in;
      end
      if (ctl.sq_load) begin
         sq_ff <= (2*SW)'(diff) * (2*SW)'(diff);
      end
   end

   assign sq = sq_ff;

endmodule

`default_nettype wire

FILE: sv/nearest_centroid_classifier_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_classifier_top : nearest centroid classifier
// Trains per-class capture rings and classifies channel samples by squared
// Euclidean distance to the truncated mean of each class's captures.
// ----------------------------------------------------------------------------
// Usage
//   req_* : one channel sample per transaction. tuser carries the mode
//           (train, classify, clear), tlast marks the final channel.
//   rsp_* : one transaction per classify transaction that has tlast set:
//           nearest class, its distance, and found in tuser.
//   csr_* : active_classes, written while the block is idle.
// Operation
//   Train and clear transactions complete at acceptance (store write included).
//   A classify transaction walks the classes through the single read port
//   of the capture store: for each class holding captures it opens the
//   class, reads every capture, forms the centroid, squares the difference
//   and accumulates; empty classes are skipped. On tlast a scan over the
//   classes picks the nearest and registers the result.
// Reset and stalls
//   Reset empties every class and the accumulators and sets active_classes
//   to 5. The store contents are not cleared. A result waits in the output
//   register while rsp_tready is low; the block keeps taking transactions
//   and only holds in its final step if a second result is ready before the
//   first has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_centroid_classifier_top #(
   parameter int CHANNELS           = 8,
   parameter int MAX_CLASSES        = 5,
   parameter int CAPTURES_PER_CLASS = 3,
   parameter int SAMPLE_BITS        = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // csr
   input  wire logic                                csr_wr_en,
   input  wire logic [ncc_pkg::CSR_W-1:0]           csr_wr_data,
   // request
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] class_id, [5:3] channel, [21:6] sample, [23:22] zero
   input  wire logic [ncc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] mode
   input  wire logic [ncc_pkg::MODE_W-1:0]          req_tuser,
   input  wire logic                                req_tlast,
   // response
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [2:0] best_class, [37:3] best_distance, [39:38] zero
   output logic      [ncc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] found
   output logic      [0:0]                          rsp_tuser
);

   import ncc_pkg::*;

   // sample width actually kept, and derived widths
   localparam int SW    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUMW  = SW + 2;
   localparam int KW    = $clog2(CAPTURES_PER_CLASS + 1);
   localparam int SLW   = (CAPTURES_PER_CLASS > 1) ? $clog2(CAPTURES_PER_CLASS) : 1;
   localparam int CIW   = $clog2(MAX_CLASSES);
   localparam int CNW   = $clog2(MAX_CLASSES + 1);
   localparam int DEPTH = MAX_CLASSES * CAPTURES_PER_CLASS * CHANNELS;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASS,
      S_READ,
      S_CENTROID,
      S_SQUARE,
      S_ACC,
      S_SCAN,
      S_RESULT
   } state_type;

   function automatic logic [AW-1:0] store_addr(input int cls, input int slot, input int ch);
      return AW'((cls * CAPTURES_PER_CLASS + slot) * CHANNELS + ch);
   endfunction

   // request fields
   logic [MODE_W-1:0]   req_mode;
   logic [CLASS_W-1:0]  req_class;
   logic [CHAN_W-1:0]   req_chan;
   logic [SW-1:0]       req_sample;
   logic                req_accept;
   logic                req_class_ok;
   logic                req_chan_ok;
   logic [CIW-1:0]      req_cidx;

   assign req_mode   = req_tuser;
   assign req_class  = req_tdata[REQ_CLASS_LSB +: CLASS_W];
   assign req_chan   = req_tdata[REQ_CHAN_LSB +: CHAN_W];
   assign req_sample = req_tdata[REQ_SAMPLE_LSB +: SW];
   assign req_accept = req_tvalid && req_tready;

   // csr register and live class count (0 acts as 1, clipped at MAX_CLASSES)
   logic [CSR_W-1:0] active_ff;
   logic [CNW-1:0]   n_live;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (active_ff == '0) begin
         n_live = CNW'(1);
      end else if (int'(active_ff) > MAX_CLASSES) begin
         n_live = CNW'(MAX_CLASSES);
      end else begin
         n_live = CNW'(active_ff);
      end
   end

   assign req_class_ok = int'(req_class) < int'(n_live);
   assign req_chan_ok  = int'(req_chan) < CHANNELS;
   assign req_cidx     = req_class[CIW-1:0];

   // control and per-class state
   state_type          state_ff;
   logic [KW-1:0]      count_ff [MAX_CLASSES];
   logic [SLW-1:0]     slot_ff  [MAX_CLASSES];
   logic [DIST_W-1:0]  acc_ff   [MAX_CLASSES];
   logic [CNW-1:0]     c_ff;
   logic [SLW-1:0]     s_ff;
   logic [SUMW-1:0]    sum_ff;
   logic [SW-1:0]      smp_ff;
   logic [CHAN_W-1:0]  ch_ff;
   logic               ch_ok_ff;
   logic               last_ff;
   logic [CIW-1:0]     best_ff;
   logic [DIST_W-1:0]  bd_ff;
   logic               found_ff;
   logic               rsp_valid_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_found_ff;

   logic [CIW-1:0]     cidx;
   logic [KW-1:0]      cur_count;
   logic               class_done;
   logic               last_slot;

   assign cidx       = c_ff[CIW-1:0];
   assign class_done = c_ff >= n_live;
   assign cur_count  = class_done ? '0 : count_ff[cidx];
   assign last_slot  = ((KW+1)'(s_ff) + (KW+1)'(1)) == (KW+1)'(cur_count);

   // capture store ports
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;
   logic [SW-1:0]   rd_data;

   assign wr_en   = req_accept && (req_mode == MODE_TRAIN) && req_class_ok && req_chan_ok;
   assign wr_addr = store_addr(int'(req_cidx), int'(slot_ff[req_cidx]), int'(req_chan));
   // slot 0 is fetched while a class is opened, the next slot while reading
   assign rd_addr = store_addr(int'(cidx), (state_ff == S_READ) ? int'(s_ff) + 1 : 0,
                               int'(ch_ff));

   ncc_capture_mem #(
      .DEPTH (DEPTH),
      .WIDTH (SW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // distance datapath
   ncc_dp_ctl_type dp_ctl;
   logic [2*SW-1:0] sq;

   assign dp_ctl.cen_load = (state_ff == S_CENTROID);
   assign dp_ctl.sq_load  = (state_ff == S_SQUARE);

   ncc_dist #(
      .SW   (SW),
      .KW   (KW),
      .SUMW (SUMW)
   ) u_dist (
      .clock  (clock),
      .ctl    (dp_ctl),
      .sum    (sum_ff),
      .count  (cur_count),
      .sample (smp_ff),
      .sq     (sq)
   );

   // saturating accumulate
   logic [DIST_W:0]    acc_sum;
   logic [DIST_W-1:0]  acc_next;
   logic [DIST_W-1:0]  cur_acc;

   assign cur_acc  = class_done ? '0 : acc_ff[cidx];
   assign acc_sum  = (DIST_W+1)'(cur_acc) + (DIST_W+1)'(sq);
   assign acc_next = (acc_sum >= (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : acc_sum[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         c_ff         <= '0;
         s_ff         <= '0;
         found_ff     <= 1'b0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            count_ff[i] <= '0;
            slot_ff[i]  <= '0;
            acc_ff[i]   <= '0;
         end
      end else begin
         // the result step reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  unique case (req_mode)
                     MODE_TRAIN: begin
                        if (req_class_ok && req_tlast) begin
                           if (slot_ff[req_cidx] == SLW'(CAPTURES_PER_CLASS - 1)) begin
                              slot_ff[req_cidx] <= '0;
                           end else begin
                              slot_ff[req_cidx] <= slot_ff[req_cidx] + SLW'(1);
                           end
                           if (count_ff[req_cidx] != KW'(CAPTURES_PER_CLASS)) begin
                              count_ff[req_cidx] <= count_ff[req_cidx] + KW'(1);
                           end
                        end
                     end
                     MODE_CLEAR: begin
                        if (req_class_ok) begin
                           count_ff[req_cidx] <= '0;
                           slot_ff[req_cidx]  <= '0;
                        end
                     end
                     MODE_CLASSIFY: begin
                        smp_ff   <= req_sample;
                        ch_ff    <= req_chan;
                        ch_ok_ff <= req_chan_ok;
                        last_ff  <= req_tlast;
                        c_ff     <= '0;
                        state_ff <= S_CLASS;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_CLASS: begin
               if (class_done || !ch_ok_ff) begin
                  if (last_ff) begin
                     c_ff     <= '0;
                     found_ff <= 1'b0;
                     best_ff  <= '0;
                     bd_ff    <= '0;
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else if (cur_count == '0) begin
                  c_ff <= c_ff + CNW'(1);
               end else begin
                  s_ff     <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               sum_ff <= sum_ff + SUMW'(rd_data);
               if (last_slot) begin
                  state_ff <= S_CENTROID;
               end else begin
                  s_ff <= s_ff + SLW'(1);
               end
            end
            S_CENTROID: begin
               state_ff <= S_SQUARE;
            end
            S_SQUARE: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff[cidx] <= acc_next;
               c_ff         <= c_ff + CNW'(1);
               state_ff     <= S_CLASS;
            end
            S_SCAN: begin
               if (class_done) begin
                  state_ff <= S_RESULT;
               end else begin
                  // strict compare keeps the lower index on a tie
                  if (cur_count != '0 && (!found_ff || cur_acc < bd_ff)) begin
                     best_ff  <= cidx;
                     bd_ff    <= cur_acc;
                     found_ff <= 1'b1;
                  end
                  c_ff <= c_ff + CNW'(1);
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_class_ff <= CLASS_W'(best_ff);
                  rsp_dist_ff  <= bd_ff;
                  rsp_found_ff <= found_ff;
                  for (int i = 0; i < MAX_CLASSES; i++) begin
                     acc_ff[i] <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - DIST_W - CLASS_W)'(0), rsp_dist_ff, rsp_class_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

`default_nettype wire

FILE: sv/ncc_checker.sv
// ----------------------------------------------------------------------------
// ncc_checker : port-level assertions for the classifier
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [ncc_pkg::MODE_W-1:0]         req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [ncc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic [0:0]                         rsp_tuser
);

   import ncc_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no trained class: class and distance read zero
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("non-zero response without a trained class");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // ready drops in the cycle after a classify transaction
   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_CLASSIFY |=> !req_tready)
      else $error("ready straight after a classify transaction");

endmodule

bind nearest_centroid_classifier_top ncc_checker u_ncc_checker (.*);

`default_nettype wire
